// File: hw/rtl/cts_pkg.sv
// Shared types, sizes and helper functions for the condensed text spacing block.
`timescale 1ns / 1ps

package cts_pkg;

	// Table and coordinate sizes.
	localparam int GLYPH_CODES = 256;
	localparam int COORD_BITS  = 8;
	localparam int CODE_W      = 8;
	localparam int IDX_W       = (GLYPH_CODES > 1) ? $clog2(GLYPH_CODES) : 1;

	// Field widths.
	localparam int GAP_W  = 11;
	localparam int MEAN_W = 8;
	localparam int SP_W   = 16;
	localparam int LL_W   = 24;
	localparam int CALC_W = SP_W + 3;
	localparam int TOT_W  = LL_W + 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_WIDTH = 1'b1;
	localparam int CFG_DATA_W = GAP_W;

	// Operation codes; the fourth code is unused.
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TEXT = 2'd1,
		OP_EOL  = 2'd2
	} op_t;

	typedef logic [COORD_BITS-1:0] coord_t;

	// Metrics of one glyph as seen by the spacing logic.
	typedef struct packed {
		logic   defined;
		logic   blank;
		coord_t left;
		coord_t right;
	} glyph_t;

	// Per-line running state.
	typedef struct packed {
		logic signed [SP_W-1:0] pending;
		logic                   seen;
		logic signed [LL_W-1:0] total;
	} line_state_t;

	// One result word.
	typedef struct packed {
		logic signed [SP_W-1:0] spacing;
		logic signed [LL_W-1:0] line_length;
		logic                   line_end;
	} result_t;

	localparam logic signed [CALC_W-1:0] SP_MAX_C = CALC_W'(2 ** (SP_W - 1) - 1);
	localparam logic signed [CALC_W-1:0] SP_MIN_C = -CALC_W'(2 ** (SP_W - 1));
	localparam logic signed [TOT_W-1:0]  LL_MAX_C = TOT_W'(2 ** (LL_W - 1) - 1);
	localparam logic signed [TOT_W-1:0]  LL_MIN_C = -TOT_W'(2 ** (LL_W - 1));

	// Saturate an intermediate spacing value to the spacing width.
	function automatic logic signed [SP_W-1:0] sat_sp(input logic signed [CALC_W-1:0] v);
		logic signed [SP_W-1:0] r;
		if (v > SP_MAX_C) begin
			r = SP_MAX_C[SP_W-1:0];
		end else if (v < SP_MIN_C) begin
			r = SP_MIN_C[SP_W-1:0];
		end else begin
			r = v[SP_W-1:0];
		end
		return r;
	endfunction

	// Saturate a running sum to the line length width.
	function automatic logic signed [LL_W-1:0] sat_ll(input logic signed [TOT_W-1:0] v);
		logic signed [LL_W-1:0] r;
		if (v > LL_MAX_C) begin
			r = LL_MAX_C[LL_W-1:0];
		end else if (v < LL_MIN_C) begin
			r = LL_MIN_C[LL_W-1:0];
		end else begin
			r = v[LL_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/condensed_text_spacing.sv
// Top level of the condensed text spacing block: handshakes, pipeline and line state.
`timescale 1ns / 1ps

// Tight spacing for a line of characters. Load words write the glyph metric table;
// text words emit the spacing before each character and end-of-line words emit
// the trailing spacing with the saturated line total, then restart the line.
// One word is accepted every cycle while the output is not stalled; a result passes
// through the first stage, with its table read, and then the output register.
// The accept rate is set by the loop through the spacing arithmetic and the line
// state register, and by the table read that is registered at acceptance.
// Load words and the unused operation code give no result. The defined flags clear
// at reset, so the block is ready at once with no clearing pass. The user must
// write configuration only while the block is idle; the block does not enforce it.

module condensed_text_spacing
	import cts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               operation,
	input  logic [CODE_W-1:0]        char_code,
	input  logic                     glyph_defined,
	input  logic                     glyph_blank,
	input  logic [7:0]               glyph_left,
	input  logic [7:0]               glyph_right,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SP_W-1:0]   spacing,
	output logic signed [LL_W-1:0]   line_length,
	output logic                     line_end
);

	logic signed [GAP_W-1:0] char_gap_q;
	logic [MEAN_W-1:0]       mean_width_q;
	line_state_t             state_q;
	line_state_t             next_state;
	logic                    valid_s1;
	logic                    line_end_s1;
	logic                    valid_s2;
	result_t                 result_s2;
	result_t                 result;
	glyph_t                  wr_glyph;
	glyph_t                  rd_glyph;
	logic                    adv;
	logic                    in_acc;
	logic                    is_load;
	logic                    is_text;
	logic                    is_eol;
	logic                    take_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_gap_q   <= '0;
			mean_width_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHAR_GAP:   char_gap_q   <= $signed(cfg_data[GAP_W-1:0]);
				REG_MEAN_WIDTH: mean_width_q <= cfg_data[MEAN_W-1:0];
				default:        ;
			endcase
		end
	end

	// Decode the operation of the incoming word.
	always_comb begin
		is_load = 1'b0;
		is_text = 1'b0;
		is_eol  = 1'b0;
		unique case (operation)
			OP_LOAD: is_load = 1'b1;
			OP_TEXT: is_text = 1'b1;
			OP_EOL:  is_eol  = 1'b1;
			default: ;
		endcase
	end

	// Handshake: the output register frees the first stage whenever it can move.
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign take_s1  = in_acc && (is_text || is_eol);

	assign wr_glyph = '{defined: glyph_defined, blank: glyph_blank,
		left: coord_t'(glyph_left), right: coord_t'(glyph_right)};

	cts_glyph_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_acc && is_load),
		.rd_en    (take_s1),
		.code     (char_code),
		.wr_glyph (wr_glyph),
		.rd_glyph (rd_glyph)
	);

	// First stage: the word waits here while its metrics come out of the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			line_end_s1 <= is_eol;
		end
	end

	cts_spacing_calc u_calc (
		.is_eol     (line_end_s1),
		.glyph      (rd_glyph),
		.state      (state_q),
		.char_gap   (char_gap_q),
		.mean_width (mean_width_q),
		.result     (result),
		.next_state (next_state)
	);

	// Line state advances as each word moves into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && adv) begin
			state_q <= next_state;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign spacing     = result_s2.spacing;
	assign line_length = result_s2.line_length;
	assign line_end    = result_s2.line_end;

	// The input is held back only while a word waits in the first stage.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty first stage");

	// A waiting word reaches the output register when the output is not stalled.
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_stall |=> valid_s2)
		else $error("first stage word did not move to the output");

	// End of line leaves a fresh line behind.
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && line_end_s1 |=> !state_q.seen && state_q.total == '0)
		else $error("line state not restarted after end of line");

	// An undefined character before any glyph of the line spaces by zero.
	a_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && !line_end_s1 && !rd_glyph.defined && !state_q.seen
		|=> spacing == '0)
		else $error("leading undefined character gave nonzero spacing");

endmodule

// File: hw/rtl/cts_glyph_store.sv
// Glyph metric table: defined flags in flip-flops, other metrics in a memory.
`timescale 1ns / 1ps

module cts_glyph_store
	import cts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [CODE_W-1:0] code,
	input  glyph_t            wr_glyph,
	output glyph_t            rd_glyph
);

	typedef struct packed {
		logic   blank;
		coord_t left;
		coord_t right;
	} metric_t;

	logic [GLYPH_CODES-1:0] defined_q;
	metric_t                mem_q [GLYPH_CODES];
	metric_t                rd_metric_q;
	logic                   rd_defined_q;
	logic                   in_table;
	logic [IDX_W-1:0]       idx;

	// Codes beyond the table are ignored on write and read as undefined.
	assign in_table = ({1'b0, code} < (CODE_W + 1)'(GLYPH_CODES));
	assign idx      = IDX_W'(code);

	// Defined flags clear at reset, so unwritten entries read as undefined.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defined_q    <= '0;
			rd_defined_q <= 1'b0;
		end else begin
			if (wr_en && in_table) begin
				defined_q[idx] <= wr_glyph.defined;
			end
			if (rd_en) begin
				rd_defined_q <= in_table && defined_q[idx];
			end
		end
	end

	// Metric memory with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en && in_table) begin
			mem_q[idx] <= '{blank: wr_glyph.blank, left: wr_glyph.left, right: wr_glyph.right};
		end
		if (rd_en) begin
			rd_metric_q <= mem_q[idx];
		end
	end

	assign rd_glyph = '{defined: rd_defined_q, blank: rd_metric_q.blank,
		left: rd_metric_q.left, right: rd_metric_q.right};

endmodule

// File: hw/rtl/cts_spacing_calc.sv
// Spacing arithmetic for one text or end-of-line word, with the next line state.
`timescale 1ns / 1ps

module cts_spacing_calc
	import cts_pkg::*;
(
	input  logic                    is_eol,
	input  glyph_t                  glyph,
	input  line_state_t             state,
	input  logic signed [GAP_W-1:0] char_gap,
	input  logic [MEAN_W-1:0]       mean_width,
	output result_t                 result,
	output line_state_t             next_state
);

	logic signed [GAP_W:0]   gap_x;
	logic signed [GAP_W:0]   gap_r;
	logic signed [GAP_W-1:0] half;
	logic signed [SP_W-1:0]  pend;
	logic signed [CALC_W-1:0] pend_x;
	logic signed [CALC_W-1:0] half_x;
	logic signed [CALC_W-1:0] left_x;
	logic signed [CALC_W-1:0] right_x;
	logic signed [SP_W-1:0]  sp;
	logic signed [SP_W-1:0]  sp_visible;
	logic signed [SP_W-1:0]  pend_visible;
	logic signed [SP_W-1:0]  pend_plain;
	logic signed [SP_W-1:0]  pend_eol;
	logic signed [LL_W-1:0]  new_total;

	// Half gap, truncated toward zero: add one before the shift when negative.
	assign gap_x = {char_gap[GAP_W-1], char_gap};
	assign gap_r = gap_x + {{GAP_W{1'b0}}, char_gap[GAP_W-1]};
	assign half  = gap_r[GAP_W:1];

	// Before the first defined glyph the live half gap stands in for the pending gap.
	assign pend    = state.seen ? state.pending : SP_W'(half);
	assign pend_x  = CALC_W'(pend);
	assign half_x  = CALC_W'(half);
	assign left_x  = $signed(CALC_W'(glyph.left));
	assign right_x = $signed(CALC_W'(glyph.right));

	assign sp_visible   = sat_sp(pend_x + half_x - left_x);
	assign pend_visible = sat_sp(right_x + half_x);
	assign pend_plain   = sat_sp(pend_x);
	assign pend_eol     = sat_sp(pend_x + half_x);

	// Pick the spacing and the gap that the word leaves pending.
	always_comb begin
		next_state = state;
		if (is_eol) begin
			sp = pend_eol;
		end else if (!glyph.defined) begin
			if (!state.seen) begin
				sp = '0;
			end else begin
				sp = pend_plain;
				next_state.pending = '0;
			end
		end else if (glyph.blank) begin
			sp = pend_plain;
			next_state.pending = $signed(SP_W'(mean_width));
			next_state.seen    = 1'b1;
		end else begin
			sp = sp_visible;
			next_state.pending = pend_visible;
			next_state.seen    = 1'b1;
		end
		next_state.total = new_total;
		// End of line restarts the line once its total has been reported.
		if (is_eol) begin
			next_state.total   = '0;
			next_state.seen    = 1'b0;
			next_state.pending = '0;
		end
	end

	assign new_total = sat_ll(TOT_W'(state.total) + TOT_W'(sp));

	assign result = '{spacing: sp, line_length: new_total, line_end: is_eol};

endmodule

// File: tb/condensed_text_spacing_tb.sv
// Self-checking testbench for the condensed text spacing block.
`timescale 1ns / 1ps

module condensed_text_spacing_tb;
	import cts_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SP_HI = 32767;
	localparam int SP_LO = -32768;
	localparam int LL_HI = 8388607;
	localparam int LL_LO = -8388608;
	localparam int FONT_LO = 32;
	localparam int FONT_HI = 95;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 200;
	localparam int STUCK_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = '0;
	logic [CODE_W-1:0] char_code = '0;
	logic glyph_defined = 1'b0;
	logic glyph_blank = 1'b0;
	logic [7:0] glyph_left = '0;
	logic [7:0] glyph_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SP_W-1:0] spacing;
	logic signed [LL_W-1:0] line_length;
	logic line_end;

	// Shadow copy of the block's font table, line state and registers.
	glyph_t font_mirror [GLYPH_CODES];
	int pend_gap = 0;
	bit line_seen = 1'b0;
	int run_total = 0;
	int gap_setting = 0;
	int mean_setting = 0;

	result_t expected_spacings [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asks = 0;
	int holds_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	condensed_text_spacing dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.char_code(char_code),
		.glyph_defined(glyph_defined),
		.glyph_blank(glyph_blank),
		.glyph_left(glyph_left),
		.glyph_right(glyph_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.spacing(spacing),
		.line_length(line_length),
		.line_end(line_end)
	);

	always #4 clk = ~clk;

	function automatic int clamp_to(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Update the shadow state for one accepted word and queue its result, if it gives one.
	function automatic void predict_spacing(input logic [1:0] op, input logic [7:0] code,
			input logic def, input logic blank, input logic [7:0] left, input logic [7:0] right);
		int half;
		int pend;
		int sp;
		glyph_t g;
		result_t r;
		half = gap_setting / 2;
		pend = line_seen ? pend_gap : half;
		g = '0;
		case (op)
			OP_LOAD: begin
				if (int'(code) < GLYPH_CODES) begin
					font_mirror[code].defined = def;
					font_mirror[code].blank = blank;
					font_mirror[code].left = coord_t'(left);
					font_mirror[code].right = coord_t'(right);
				end
				return;
			end
			OP_TEXT: begin
				if (int'(code) < GLYPH_CODES)
					g = font_mirror[code];
				if (!g.defined) begin
					if (!line_seen) begin
						sp = 0;
					end else begin
						sp = clamp_to(pend, SP_LO, SP_HI);
						pend_gap = 0;
					end
				end else if (g.blank) begin
					sp = clamp_to(pend, SP_LO, SP_HI);
					pend_gap = mean_setting;
					line_seen = 1'b1;
				end else begin
					sp = clamp_to(pend + half - int'(g.left), SP_LO, SP_HI);
					pend_gap = clamp_to(int'(g.right) + half, SP_LO, SP_HI);
					line_seen = 1'b1;
				end
			end
			OP_EOL: begin
				sp = clamp_to(pend + half, SP_LO, SP_HI);
			end
			default: return;
		endcase
		run_total = clamp_to(run_total + sp, LL_LO, LL_HI);
		r.spacing = sp[SP_W-1:0];
		r.line_length = run_total[LL_W-1:0];
		r.line_end = (op == OP_EOL);
		expected_spacings.push_back(r);
		// End of line restarts the line.
		if (op == OP_EOL) begin
			run_total = 0;
			line_seen = 1'b0;
			pend_gap = half;
		end
	endfunction

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (out_valid && !out_stall) begin
			if (expected_spacings.size() == 0) begin
				$error("unexpected result word: spacing %0d, line_length %0d, line_end %0b",
					spacing, line_length, line_end);
				mismatches++;
			end else begin
				want = expected_spacings.pop_front();
				if (spacing !== want.spacing) begin
					$error("spacing: expected %0d, got %0d", want.spacing, spacing);
					mismatches++;
				end
				if (line_length !== want.line_length) begin
					$error("line_length: expected %0d, got %0d", want.line_length, line_length);
					mismatches++;
				end
				if (line_end !== want.line_end) begin
					$error("line_end: expected %0b, got %0b", want.line_end, line_end);
					mismatches++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (hold_asks != holds_seen) begin
			holds_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STUCK_LIMIT) begin
			$display("condensed_text_spacing_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one word, wait until it is taken, and predict its result.
	// Valid is left high on return; the caller either sends again or drains.
	task automatic send_word(input logic [1:0] op, input logic [7:0] code, input logic def,
			input logic blank, input logic [7:0] left, input logic [7:0] right);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		char_code <= code;
		glyph_defined <= def;
		glyph_blank <= blank;
		glyph_left <= left;
		glyph_right <= right;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_spacing(op, code, def, blank, left, right);
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] code);
		send_word(OP_TEXT, code, 1'($urandom_range(1)), 1'($urandom_range(1)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic send_eol();
		send_word(OP_EOL, 8'($urandom_range(255)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	// Stop offering and wait until every expected result has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_spacings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_CHAR_GAP)
			gap_setting = value;
		else
			mean_setting = value & 8'hff;
	endtask

	task automatic set_spacing(input int gap, input int mean);
		drain();
		write_reg(REG_CHAR_GAP, gap);
		write_reg(REG_MEAN_WIDTH, mean);
	endtask

	// One random word: mostly text drawn from the loaded font, some line ends,
	// occasional table loads and a little unused-operation noise.
	task automatic random_word();
		int pick;
		logic [7:0] code;
		pick = $urandom_range(99);
		if (pick < 8) begin
			code = $urandom_range(1) ? 8'($urandom_range(FONT_HI, FONT_LO))
				: 8'($urandom_range(255));
			send_word(OP_LOAD, code, 1'($urandom_range(3) != 0), 1'($urandom_range(3) == 0),
				8'($urandom_range(255)), 8'($urandom_range(255)));
		end else if (pick < 10) begin
			send_word(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		end else if (pick < 22) begin
			send_eol();
		end else if (pick < 80) begin
			send_text(8'($urandom_range(FONT_HI, FONT_LO)));
		end else begin
			send_text(8'($urandom_range(255)));
		end
	endtask

	// Right after reset: unwritten codes read as undefined and a bare line end.
	task automatic test_reset_state();
		send_text(8'd0);
		send_word(OP_UNUSED, 8'hff, 1'b1, 1'b1, 8'hff, 8'hff);
		send_eol();
		drain();
	endtask

	// Metric and register extremes, blank and undefined glyphs, empty lines.
	task automatic test_metric_extremes();
		set_spacing(-1024, 255);
		send_word(OP_LOAD, 8'd0, 1'b1, 1'b0, 8'hff, 8'hff);
		send_word(OP_LOAD, 8'hff, 1'b1, 1'b0, 8'h00, 8'h00);
		send_word(OP_LOAD, 8'd32, 1'b1, 1'b1, 8'h00, 8'h00);
		send_word(OP_LOAD, 8'd7, 1'b0, 1'b1, 8'hff, 8'hff);
		send_text(8'd7);
		send_text(8'd0);
		send_text(8'hff);
		send_text(8'd32);
		send_text(8'd0);
		send_text(8'd7);
		send_text(8'd0);
		send_eol();
		send_eol();
		set_spacing(1023, 0);
		send_text(8'hff);
		send_text(8'd32);
		send_text(8'd7);
		send_text(8'hff);
		send_eol();
		// Odd negative gap: the half truncates toward zero.
		set_spacing(-7, 1);
		send_text(8'd0);
		send_eol();
		drain();
	endtask

	// Give the font range random metrics before the random runs.
	task automatic test_font_load();
		for (int c = FONT_LO; c <= FONT_HI; c++)
			send_word(OP_LOAD, 8'(c), 1'($urandom_range(7) != 0), 1'($urandom_range(5) == 0),
				8'($urandom_range(255)), 8'($urandom_range(255)));
		drain();
	endtask

	// Random lines under one idling pattern, over several register settings.
	task automatic test_random_text(input int send_pct, input int recv_pct, input int words);
		for (int phase = 0; phase < 3; phase++) begin
			set_spacing($urandom_range(2047) - 1024, $urandom_range(255));
			send_idle_pct = send_pct;
			recv_stall_pct = recv_pct;
			repeat (words) random_word();
		end
		drain();
	endtask

	// The receiver holds off for a long stretch while words keep coming.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_spacing(3, 9);
		hold_asks++;
		for (int i = 0; i < 80; i++) begin
			if (i % 10 == 9)
				send_eol();
			else
				send_text(8'($urandom_range(FONT_HI, FONT_LO)));
		end
		drain();
	endtask

	initial begin
		foreach (font_mirror[i])
			font_mirror[i] = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_metric_extremes();
		test_font_load();
		test_random_text(36, 46, 200);
		test_random_text(46, 36, 200);
		test_random_text(0, 0, 200);
		test_output_backpressure();

		drain();
		if (mismatches == 0) begin
			$display("condensed_text_spacing_tb OK");
		end else begin
			$display("condensed_text_spacing_tb NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/cts_pkg.sv
hw/rtl/cts_glyph_store.sv
hw/rtl/cts_spacing_calc.sv
hw/rtl/condensed_text_spacing.sv
tb/condensed_text_spacing_tb.sv
